// ===== rtl/mrrp_pkg.sv =====
// ----------------------------------------------------------------------------
// mrrp_pkg
// Shared types for the Modbus RTU response parser: byte operation codes and
// the entry that the front end hands to the back end through the queue.
// ----------------------------------------------------------------------------
`default_nettype none

package mrrp_pkg;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam logic [15:0] CRC_SEED  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic ACT_RX_BYTE  = 1'b0;
  localparam logic ACT_REQ_SENT = 1'b1;

  typedef enum logic [3:0] {
    OP_NODE,
    OP_FUNC,
    OP_ADDR_HI,
    OP_ADDR_LO,
    OP_QTY_HI,
    OP_QTY_LO,
    OP_COUNT,
    OP_DATA,
    OP_CRC_LO,
    OP_CRC_HI,
    OP_PRELOAD
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  rx_byte;
    logic [7:0]  index;
    logic [15:0] req_address;
    logic [15:0] req_quantity;
    logic [7:0]  req_byte_count;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/mrrp_front.sv =====
// ----------------------------------------------------------------------------
// mrrp_front
// Frame sequencer: accepts input items, tracks the field position and data
// pointer, and tags each item with the operation the back end must apply.
// ----------------------------------------------------------------------------
`default_nettype none

module mrrp_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_action,
  input  wire logic [7:0]        in_rx_byte,
  input  wire logic [15:0]       in_req_address,
  input  wire logic [15:0]       in_req_quantity,
  input  wire logic [7:0]        in_req_byte_count,
  output logic                   push,
  output mrrp_pkg::entry_t       push_entry,
  input  wire logic              q_full
);

  typedef enum logic [3:0] {
    POS_NODE,
    POS_FUNC,
    POS_ADDR_HI,
    POS_ADDR_LO,
    POS_QTY_HI,
    POS_QTY_LO,
    POS_COUNT,
    POS_DATA,
    POS_CRC_LO,
    POS_CRC_HI
  } pos_t;

  pos_t       pos_r, pos_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] ptr_r, ptr_nxt;
  logic [7:0] ptr_inc;
  mrrp_pkg::op_t op;

  assign in_ready = ~q_full;
  assign push     = in_valid & in_ready;
  assign ptr_inc  = ptr_r + 8'd1;

  always_comb begin
    pos_nxt = pos_r;
    cnt_nxt = cnt_r;
    ptr_nxt = ptr_r;
    op      = mrrp_pkg::OP_NODE;
    if (in_action == mrrp_pkg::ACT_REQ_SENT) begin
      op      = mrrp_pkg::OP_PRELOAD;
      cnt_nxt = in_req_byte_count;
    end else begin
      unique case (pos_r)
        POS_FUNC: begin
          op      = mrrp_pkg::OP_FUNC;
          pos_nxt = (in_rx_byte >= 8'd1 && in_rx_byte <= 8'd4) ? POS_COUNT : POS_ADDR_HI;
        end
        POS_ADDR_HI: begin
          op      = mrrp_pkg::OP_ADDR_HI;
          pos_nxt = POS_ADDR_LO;
        end
        POS_ADDR_LO: begin
          op      = mrrp_pkg::OP_ADDR_LO;
          pos_nxt = POS_QTY_HI;
        end
        POS_QTY_HI: begin
          op      = mrrp_pkg::OP_QTY_HI;
          pos_nxt = POS_QTY_LO;
        end
        POS_QTY_LO: begin
          op      = mrrp_pkg::OP_QTY_LO;
          pos_nxt = POS_CRC_LO;
        end
        POS_COUNT: begin
          op      = mrrp_pkg::OP_COUNT;
          cnt_nxt = in_rx_byte;
          ptr_nxt = 8'd0;
          pos_nxt = (in_rx_byte == 8'd0) ? POS_CRC_LO : POS_DATA;
        end
        POS_DATA: begin
          // pointer wraps at 8 bits; a preload may drop the count below it
          op      = mrrp_pkg::OP_DATA;
          ptr_nxt = ptr_inc;
          if (ptr_inc >= cnt_r) begin
            pos_nxt = POS_CRC_LO;
          end
        end
        POS_CRC_LO: begin
          op      = mrrp_pkg::OP_CRC_LO;
          pos_nxt = POS_CRC_HI;
        end
        POS_CRC_HI: begin
          op      = mrrp_pkg::OP_CRC_HI;
          pos_nxt = POS_NODE;
        end
        default: begin
          op      = mrrp_pkg::OP_NODE;
          pos_nxt = POS_FUNC;
        end
      endcase
    end
  end

  always_comb begin
    push_entry.op             = op;
    push_entry.rx_byte        = in_rx_byte;
    push_entry.index          = ptr_r ^ 8'd1;
    push_entry.req_address    = in_req_address;
    push_entry.req_quantity   = in_req_quantity;
    push_entry.req_byte_count = in_req_byte_count;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_NODE;
      cnt_r <= 8'd0;
      ptr_r <= 8'd0;
    end else if (push) begin
      pos_r <= pos_nxt;
      cnt_r <= cnt_nxt;
      ptr_r <= ptr_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mrrp_queue.sv =====
// ----------------------------------------------------------------------------
// mrrp_queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mrrp_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire mrrp_pkg::entry_t  push_entry,
  output logic                   full,
  output logic                   q_valid,
  output mrrp_pkg::entry_t       q_entry,
  input  wire logic              pop
);

  mrrp_pkg::entry_t mem_r [mrrp_pkg::QDEPTH];

  logic [mrrp_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [mrrp_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == mrrp_pkg::QCNT_W'(mrrp_pkg::QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_entry = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + mrrp_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - mrrp_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // depth is a power of two, so the pointers wrap on their own
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mrrp_back.sv =====
// ----------------------------------------------------------------------------
// mrrp_back
// Executes tagged byte operations: CRC-16 update, header capture, request
// preload, and result formatting into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mrrp_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire mrrp_pkg::entry_t  q_entry,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_kind,
  output logic [7:0]             out_data_byte,
  output logic [7:0]             out_data_index,
  output logic [7:0]             out_node_addr,
  output logic [7:0]             out_function_code,
  output logic [15:0]            out_table_address,
  output logic [15:0]            out_element_quantity,
  output logic [7:0]             out_byte_count,
  output logic                   out_crc_ok
);

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ mrrp_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  node_r, node_nxt;
  logic [7:0]  func_r, func_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [15:0] qty_r, qty_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;

  logic        out_valid_r;
  logic        kind_r;
  logic [7:0]  data_byte_r, data_index_r, node_out_r, func_out_r, count_out_r;
  logic [15:0] addr_out_r, qty_out_r;
  logic        crc_ok_r;

  logic        emits;
  logic [15:0] crc_upd;
  logic [15:0] rx_crc;

  assign emits   = (q_entry.op == mrrp_pkg::OP_DATA) || (q_entry.op == mrrp_pkg::OP_CRC_HI);
  assign pop     = q_valid && (!emits || !out_valid_r || out_ready);
  assign crc_upd = crc_byte(crc_r, q_entry.rx_byte);
  assign rx_crc  = {q_entry.rx_byte, crc_lo_r};

  always_comb begin
    crc_nxt    = crc_r;
    node_nxt   = node_r;
    func_nxt   = func_r;
    addr_nxt   = addr_r;
    qty_nxt    = qty_r;
    cnt_nxt    = cnt_r;
    crc_lo_nxt = crc_lo_r;
    unique case (q_entry.op)
      mrrp_pkg::OP_NODE: begin
        crc_nxt  = crc_byte(mrrp_pkg::CRC_SEED, q_entry.rx_byte);
        node_nxt = q_entry.rx_byte;
      end
      mrrp_pkg::OP_FUNC: begin
        crc_nxt  = crc_upd;
        func_nxt = q_entry.rx_byte;
      end
      mrrp_pkg::OP_ADDR_HI: begin
        crc_nxt  = crc_upd;
        addr_nxt = {q_entry.rx_byte, 8'd0};
      end
      mrrp_pkg::OP_ADDR_LO: begin
        crc_nxt  = crc_upd;
        addr_nxt = {addr_r[15:8], q_entry.rx_byte};
      end
      mrrp_pkg::OP_QTY_HI: begin
        crc_nxt = crc_upd;
        qty_nxt = {q_entry.rx_byte, 8'd0};
      end
      mrrp_pkg::OP_QTY_LO: begin
        crc_nxt = crc_upd;
        qty_nxt = {qty_r[15:8], q_entry.rx_byte};
      end
      mrrp_pkg::OP_COUNT: begin
        crc_nxt = crc_upd;
        cnt_nxt = q_entry.rx_byte;
      end
      mrrp_pkg::OP_DATA: begin
        crc_nxt = crc_upd;
      end
      mrrp_pkg::OP_CRC_LO: begin
        crc_lo_nxt = q_entry.rx_byte;
      end
      mrrp_pkg::OP_PRELOAD: begin
        addr_nxt = q_entry.req_address;
        qty_nxt  = q_entry.req_quantity;
        cnt_nxt  = q_entry.req_byte_count;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= mrrp_pkg::CRC_SEED;
      node_r      <= 8'd0;
      func_r      <= 8'd0;
      addr_r      <= 16'd0;
      qty_r       <= 16'd0;
      cnt_r       <= 8'd0;
      crc_lo_r    <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        crc_r    <= crc_nxt;
        node_r   <= node_nxt;
        func_r   <= func_nxt;
        addr_r   <= addr_nxt;
        qty_r    <= qty_nxt;
        cnt_r    <= cnt_nxt;
        crc_lo_r <= crc_lo_nxt;
      end
      if (pop && emits) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload; unused fields of each kind read as zero
  always_ff @(posedge clk) begin
    if (pop && emits) begin
      if (q_entry.op == mrrp_pkg::OP_DATA) begin
        kind_r       <= mrrp_pkg::KIND_DATA;
        data_byte_r  <= q_entry.rx_byte;
        data_index_r <= q_entry.index;
        node_out_r   <= 8'd0;
        func_out_r   <= 8'd0;
        addr_out_r   <= 16'd0;
        qty_out_r    <= 16'd0;
        count_out_r  <= 8'd0;
        crc_ok_r     <= 1'b0;
      end else begin
        kind_r       <= mrrp_pkg::KIND_END;
        data_byte_r  <= 8'd0;
        data_index_r <= 8'd0;
        node_out_r   <= node_r;
        func_out_r   <= func_r;
        addr_out_r   <= addr_r;
        qty_out_r    <= qty_r;
        count_out_r  <= cnt_r;
        crc_ok_r     <= (rx_crc == crc_r);
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_kind             = kind_r;
  assign out_data_byte        = data_byte_r;
  assign out_data_index       = data_index_r;
  assign out_node_addr        = node_out_r;
  assign out_function_code    = func_out_r;
  assign out_table_address    = addr_out_r;
  assign out_element_quantity = qty_out_r;
  assign out_byte_count       = count_out_r;
  assign out_crc_ok           = crc_ok_r;

endmodule

`default_nettype wire

// ===== rtl/modbus_rtu_response_parser.sv =====
// ----------------------------------------------------------------------------
// modbus_rtu_response_parser
// Byte-wise Modbus RTU response parser with CRC-16 check.
// ----------------------------------------------------------------------------
// Takes one item per cycle while in_ready is high: a received byte (action 0)
// or a request-sent preload of address, quantity and byte count (action 1).
// For function codes 1 to 4 each data byte comes out as a data result at
// index (arrival index xor 1); every frame closes with a frame-end result
// carrying node, function, address, quantity, byte count and a CRC-ok flag
// (CRC-16, poly 0xA001, seed 0xFFFF). Each input transfer is written into
// the two-entry queue, then popped by the CRC/record stage feeding the
// output register. Sustained rate is one item per cycle while the result
// side keeps taking transfers; a stalled output backs up through the queue
// to in_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_response_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_action,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic [15:0] in_req_address,
  input  wire logic [15:0] in_req_quantity,
  input  wire logic [7:0]  in_req_byte_count,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_kind,
  output logic [7:0]       out_data_byte,
  output logic [7:0]       out_data_index,
  output logic [7:0]       out_node_addr,
  output logic [7:0]       out_function_code,
  output logic [15:0]      out_table_address,
  output logic [15:0]      out_element_quantity,
  output logic [7:0]       out_byte_count,
  output logic             out_crc_ok
);

  logic             push, q_full, q_valid, pop;
  mrrp_pkg::entry_t push_entry, q_entry;

  mrrp_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_rx_byte        (in_rx_byte),
    .in_req_address    (in_req_address),
    .in_req_quantity   (in_req_quantity),
    .in_req_byte_count (in_req_byte_count),
    .push              (push),
    .push_entry        (push_entry),
    .q_full            (q_full)
  );

  mrrp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .pop        (pop)
  );

  mrrp_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_valid              (q_valid),
    .q_entry              (q_entry),
    .pop                  (pop),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_kind             (out_kind),
    .out_data_byte        (out_data_byte),
    .out_data_index       (out_data_index),
    .out_node_addr        (out_node_addr),
    .out_function_code    (out_function_code),
    .out_table_address    (out_table_address),
    .out_element_quantity (out_element_quantity),
    .out_byte_count       (out_byte_count),
    .out_crc_ok           (out_crc_ok)
  );

endmodule

`default_nettype wire
